// ----- hw/rtl/sme_pkg.sv -----
package sme_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAR_COUNT_DEF   = 64;
    localparam int PROG_DEPTH_DEF  = 4096;

    localparam int CMD_W  = 5;
    localparam int DATA_W = 32;
    localparam int VIDX_W = 6;
    localparam int PC_W   = 12;
    localparam int ERR_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_CONST    = 5'd0,
        OP_STORE    = 5'd1,
        OP_LOAD     = 5'd2,
        OP_ADD      = 5'd3,
        OP_SUB      = 5'd4,
        OP_MUL      = 5'd5,
        OP_DIV      = 5'd6,
        OP_LT       = 5'd7,
        OP_GT       = 5'd8,
        OP_EQ       = 5'd9,
        OP_AND      = 5'd10,
        OP_OR       = 5'd11,
        OP_NOT      = 5'd12,
        OP_JUMP     = 5'd13,
        OP_JUMPZERO = 5'd14,
        OP_PRINT    = 5'd15,
        OP_NOP      = 5'd16,
        OP_STOP     = 5'd17
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_WRITE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch input transaction
        logic read;       // launch stack/variable reads
        logic exec;       // evaluate and register operation result
        logic div_start;  // start divider
        logic commit;     // update state, load output register
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_needed;
    } stat_t;

endpackage

// ----- hw/rtl/sme_divider.sv -----
module sme_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sme_pkg::DATA_W-1:0] dividend,
    input  logic [sme_pkg::DATA_W-1:0] divisor,
    output logic                      busy,
    output logic [sme_pkg::DATA_W-1:0] quotient
);
    import sme_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] mag_a, mag_b;

    assign mag_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = mag_a;
            den_next  = mag_b;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ----- hw/rtl/sme_datapath.sv -----
module sme_datapath #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = sme_pkg::VAR_COUNT_DEF,
    parameter int PROG_DEPTH  = sme_pkg::PROG_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sme_pkg::ctrl_t              ctrl,
    output sme_pkg::stat_t              stat,
    input  logic [sme_pkg::CMD_W-1:0]   s_cmd,
    input  logic signed [sme_pkg::DATA_W-1:0] s_imm_value,
    input  logic [sme_pkg::VIDX_W-1:0]  s_var_index,
    input  logic [sme_pkg::PC_W-1:0]    s_jump_target,
    output logic [sme_pkg::PC_W-1:0]    m_next_pc,
    output logic                        m_print_valid,
    output logic signed [sme_pkg::DATA_W-1:0] m_print_value,
    output logic                        m_halted,
    output logic [sme_pkg::ERR_W-1:0]   m_error_code
);
    import sme_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VA_W  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int PCI_W = $clog2(PROG_DEPTH);

    // storage
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] var_mem   [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_valid_reg;

    // captured transaction
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [VA_W-1:0]   vidx_reg;
    logic [PCI_W-1:0]  jt_reg;

    // architectural state
    logic [SP_W-1:0]   sp_reg;
    logic [PCI_W-1:0]  pc_reg;
    logic              halt_reg;

    // read data
    logic [DATA_W-1:0] top_reg, sec_reg, var_rd_reg;
    logic              var_ok_reg;

    // executed result
    logic [DATA_W-1:0] res_reg;
    logic [ERR_W-1:0]  err_reg;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] quot;
    logic              div_busy;

    logic [DATA_W-1:0] a_val, b_val, var_val;
    logic [DATA_W-1:0] res_next;
    logic [ERR_W-1:0]  err_next;
    logic [SP_W-1:0]   sp_m1, sp_m2;

    assign sp_m1   = sp_reg - 1'b1;
    assign sp_m2   = sp_reg - SP_W'(2);
    assign a_val   = sec_reg;
    assign b_val   = top_reg;
    assign var_val = var_ok_reg ? var_rd_reg : '0;

    // operand fetch registers
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg  <= s_cmd;
            imm_reg  <= s_imm_value;
            vidx_reg <= VA_W'(32'(s_var_index) % VAR_COUNT);
            jt_reg   <= PCI_W'(32'(s_jump_target) % PROG_DEPTH);
        end
        if (ctrl.read) begin
            top_reg    <= stack_mem[sp_m1[SA_W-1:0]];
            sec_reg    <= stack_mem[sp_m2[SA_W-1:0]];
            var_rd_reg <= var_mem[vidx_reg];
            var_ok_reg <= var_valid_reg[vidx_reg];
        end
    end

    assign prod = a_val * b_val;

    sme_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (a_val),
        .divisor  (b_val),
        .busy     (div_busy),
        .quotient (quot)
    );

    // operation evaluation
    always_comb begin
        res_next = '0;
        err_next = ERR_NONE;
        case (cmd_reg)
            OP_CONST, OP_LOAD: begin
                if (sp_reg >= SP_W'(STACK_DEPTH)) err_next = ERR_OVERFLOW;
                res_next = (cmd_reg == OP_CONST) ? imm_reg : var_val;
            end
            OP_STORE, OP_NOT, OP_JUMPZERO, OP_PRINT: begin
                if (sp_reg < SP_W'(1)) err_next = ERR_UNDERFLOW;
                res_next = (b_val == '0) ? DATA_W'(1) : '0;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_AND, OP_OR: begin
                if (sp_reg < SP_W'(2)) err_next = ERR_UNDERFLOW;
                else if (cmd_reg == OP_DIV && b_val == '0) err_next = ERR_DIVZERO;
                case (cmd_reg)
                    OP_ADD: res_next = a_val + b_val;
                    OP_SUB: res_next = a_val - b_val;
                    OP_MUL: res_next = prod;
                    OP_LT:  res_next = DATA_W'($signed(a_val) < $signed(b_val));
                    OP_GT:  res_next = DATA_W'($signed(a_val) > $signed(b_val));
                    OP_EQ:  res_next = DATA_W'(a_val == b_val);
                    OP_AND: res_next = DATA_W'((a_val != '0) && (b_val != '0));
                    OP_OR:  res_next = DATA_W'((a_val != '0) || (b_val != '0));
                    default: res_next = '0;
                endcase
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            res_reg <= res_next;
            err_reg <= err_next;
        end
    end

    assign stat.div_busy   = div_busy;
    assign stat.div_needed = (cmd_reg == OP_DIV) && (err_next == ERR_NONE);

    // commit: state update and output register
    logic [DATA_W-1:0] final_res;
    logic [PCI_W-1:0]  pc_inc;
    assign final_res = (cmd_reg == OP_DIV) ? quot : res_reg;
    assign pc_inc    = PCI_W'((32'(pc_reg) + 1) % PROG_DEPTH);

    always_ff @(posedge aclk) begin
        if (ctrl.commit && !halt_reg && err_reg == ERR_NONE) begin
            case (cmd_reg)
                OP_CONST, OP_LOAD: stack_mem[sp_reg[SA_W-1:0]] <= final_res;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_AND,
                OP_OR:             stack_mem[sp_m2[SA_W-1:0]] <= final_res;
                OP_NOT:            stack_mem[sp_m1[SA_W-1:0]] <= final_res;
                OP_STORE:          var_mem[vidx_reg] <= top_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg        <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            var_valid_reg <= '0;
            m_print_valid <= 1'b0;
            m_halted      <= 1'b0;
            m_error_code  <= ERR_NONE;
            m_next_pc     <= '0;
            m_print_value <= '0;
        end else if (ctrl.commit) begin
            if (halt_reg) begin
                m_next_pc     <= PC_W'(pc_reg);
                m_print_valid <= 1'b0;
                m_print_value <= '0;
                m_halted      <= 1'b1;
                m_error_code  <= ERR_NONE;
            end else begin
                m_next_pc     <= PC_W'(pc_inc);
                pc_reg        <= pc_inc;
                m_print_valid <= 1'b0;
                m_print_value <= '0;
                m_error_code  <= err_reg;
                m_halted      <= 1'b0;
                if (err_reg == ERR_NONE) begin
                    case (cmd_reg)
                        OP_CONST, OP_LOAD: sp_reg <= sp_reg + 1'b1;
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ,
                        OP_AND, OP_OR: sp_reg <= sp_m1;
                        OP_STORE: begin
                            sp_reg <= sp_m1;
                            var_valid_reg[vidx_reg] <= 1'b1;
                        end
                        OP_JUMPZERO: begin
                            sp_reg <= sp_m1;
                            if (top_reg == '0) begin
                                m_next_pc <= PC_W'(jt_reg);
                                pc_reg    <= jt_reg;
                            end
                        end
                        OP_PRINT: begin
                            sp_reg        <= sp_m1;
                            m_print_valid <= 1'b1;
                            m_print_value <= top_reg;
                        end
                        OP_JUMP: begin
                            m_next_pc <= PC_W'(jt_reg);
                            pc_reg    <= jt_reg;
                        end
                        OP_STOP: begin
                            halt_reg <= 1'b1;
                            m_halted <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // stack pointer never exceeds depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // halt is sticky
    assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    // divide by zero never reaches the divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_start |-> b_val != '0)
        else $error("divider started with zero divisor");

endmodule

// ----- hw/rtl/sme_ctrl.sv -----
module sme_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  sme_pkg::stat_t stat,
    output sme_pkg::ctrl_t ctrl
);
    import sme_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    // output register can take a new result
    assign slot_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = stat.div_needed ? ST_DIV : ST_WRITE;
            ST_DIV:   state_next = ST_WRITE;
            ST_WRITE: if (!stat.div_busy && slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.capture = s_valid;
            end
            ST_READ:  ctrl.read = 1'b1;
            ST_EXEC:  ctrl.exec = 1'b1;
            ST_DIV:   ctrl.div_start = 1'b1;
            ST_WRITE: ctrl.commit = !stat.div_busy && slot_free;
            default: ;
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // input accepted only while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (state_reg == ST_IDLE))
        else $error("input accepted while busy");

    // commit leads to output
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_valid)
        else $error("commit without output");

    // result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    // divide path goes through divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_start |=> stat.div_busy)
        else $error("divider did not start");

endmodule

// ----- hw/rtl/stack_machine_executor_top.sv -----
// stack machine executor
// input channel s_*: one decoded instruction per transaction (cmd,
// imm_value, var_index, jump_target), valid/ready handshake
// output channel m_*: one result per instruction (next_pc, print flag and
// value, halted, error_code)
// most opcodes pass through the read, exec and write states before m_valid
// rises; div also passes through the div state and then waits in write while
// a radix-2 iterative divider works through its 32 quotient bit steps
// instructions are taken one at a time: a new one is accepted only after the
// last one commits; s_ready is high only while the controller is idle
// reset (aresetn low, synchronous): empty stack, variables read zero,
// pc zero, halt cleared, no result pending
// when the receiver stalls the result holds on m_*; one more instruction
// can be accepted and executed, and it waits at commit until the output
// register is free
// after stop, later instructions return the held pc with halted set
module stack_machine_executor_top #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = sme_pkg::VAR_COUNT_DEF,
    parameter int PROG_DEPTH  = sme_pkg::PROG_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sme_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [sme_pkg::DATA_W-1:0] s_imm_value,
    input  logic [sme_pkg::VIDX_W-1:0]        s_var_index,
    input  logic [sme_pkg::PC_W-1:0]          s_jump_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sme_pkg::PC_W-1:0]          m_next_pc,
    output logic                              m_print_valid,
    output logic signed [sme_pkg::DATA_W-1:0] m_print_value,
    output logic                              m_halted,
    output logic [sme_pkg::ERR_W-1:0]         m_error_code
);
    import sme_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    sme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_COUNT   (VAR_COUNT),
        .PROG_DEPTH  (PROG_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_imm_value   (s_imm_value),
        .s_var_index   (s_var_index),
        .s_jump_target (s_jump_target),
        .m_next_pc     (m_next_pc),
        .m_print_valid (m_print_valid),
        .m_print_value (m_print_value),
        .m_halted      (m_halted),
        .m_error_code  (m_error_code)
    );

endmodule
